>>> sv/tldc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes of the two-level cache.
package tldc_pkg;

  localparam int unsigned L1_LINE_COUNT = 256;
  localparam int unsigned L2_LINE_COUNT = 512;
  localparam int unsigned LINE_BYTES    = 64;
  localparam int unsigned MEMORY_BYTES  = 1048576;
  localparam int unsigned WORD_BYTES    = 4;

  localparam int unsigned WORD_W     = 8 * WORD_BYTES;
  localparam int unsigned LINE_W     = 8 * LINE_BYTES;
  localparam int unsigned OFF_W      = $clog2(LINE_BYTES);
  localparam int unsigned ADDR_W     = $clog2(MEMORY_BYTES);
  localparam int unsigned BLK_W      = ADDR_W - OFF_W;
  localparam int unsigned MEM_BLOCKS = MEMORY_BYTES / LINE_BYTES;
  localparam int unsigned WIDX_W     = $clog2(LINE_BYTES / WORD_BYTES);
  localparam int unsigned L1_IDX_W   = $clog2(L1_LINE_COUNT);
  localparam int unsigned L1_TAG_W   = BLK_W - L1_IDX_W;
  localparam int unsigned L2_IDX_W   = $clog2(L2_LINE_COUNT);
  localparam int unsigned L2_TAG_W   = BLK_W - L2_IDX_W;
  localparam int unsigned CLR_W      = (L1_IDX_W > L2_IDX_W) ? L1_IDX_W : L2_IDX_W;
  localparam int unsigned CLR_LINES  = (L1_LINE_COUNT > L2_LINE_COUNT) ?
                                       L1_LINE_COUNT : L2_LINE_COUNT;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COST_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEM_RD = 3'd0,
    REG_MEM_WR = 3'd1,
    REG_L1_RD  = 3'd2,
    REG_L1_WR  = 3'd3,
    REG_L2_RD  = 3'd4,
    REG_L2_WR  = 3'd5
  } cfg_reg_e;

  // one decoded request word
  typedef struct packed {
    logic              wr;
    logic              range_err;
    logic [BLK_W-1:0]  blk;
    logic [WIDX_W-1:0] widx;
    logic [WORD_W-1:0] wdata;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [L1_TAG_W-1:0] tag;
  } l1_meta_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [L2_TAG_W-1:0] tag;
  } l2_meta_t;

  // queue to back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

endpackage

>>> sv/tldc_front.sv
`timescale 1ns / 1ps
// Front end: takes request words, classifies range, queues them for the engine.
module tldc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [31:0]               address_i,
  input  logic [31:0]               write_word_i,
  output tldc_pkg::q_out_t          q_o,
  input  logic                      pop_i
);

  tldc_pkg::item_t                     q_mem [tldc_pkg::QDEPTH];
  logic [tldc_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tldc_pkg::QCNT_W-1:0]         cnt_q, cnt_d;
  logic                                push, pop;
  tldc_pkg::item_t                     new_item;

  always_comb begin
    new_item.wr        = action_i;
    new_item.range_err = |address_i[31:tldc_pkg::ADDR_W];
    new_item.blk       = address_i[tldc_pkg::ADDR_W-1:tldc_pkg::OFF_W];
    new_item.widx      = address_i[tldc_pkg::OFF_W-1:2];
    new_item.wdata     = write_word_i;
  end

  assign in_stall_o = (cnt_q == tldc_pkg::QCNT_W'(tldc_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);
  assign q_o.valid  = (cnt_q != '0);
  assign q_o.item   = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tldc_pkg::QPTR_W'(tldc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tldc_pkg::QPTR_W'(tldc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_item;
    end
  end

endmodule

>>> sv/tldc_back.sv
`timescale 1ns / 1ps
// Back end: cache sequencer over L1, L2 and main memory, cost counter, result register.
module tldc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tldc_pkg::q_out_t                  q_i,
  output logic                              pop_o,
  input  logic                              cfg_we_i,
  input  logic [tldc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tldc_pkg::COST_W-1:0]       cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [31:0]                       read_word_o,
  output logic                              l1_hit_o,
  output logic                              l2_hit_o,
  output logic [31:0]                       elapsed_time_o,
  output logic                              range_error_o
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_L1RD, ST_L1CHK, ST_L2RD, ST_L2CHK,
    ST_MEMRD, ST_MEMCHK, ST_MEMWB, ST_L2APPLY, ST_WORD, ST_DONE
  } state_e;

  state_e state_q;

  // memories
  tldc_pkg::l1_meta_t             l1_meta_mem [tldc_pkg::L1_LINE_COUNT];
  logic [tldc_pkg::LINE_W-1:0]    l1_data_mem [tldc_pkg::L1_LINE_COUNT];
  tldc_pkg::l2_meta_t             l2_meta_mem [tldc_pkg::L2_LINE_COUNT];
  logic [tldc_pkg::LINE_W-1:0]    l2_data_mem [tldc_pkg::L2_LINE_COUNT];
  logic [tldc_pkg::LINE_W-1:0]    main_mem    [tldc_pkg::MEM_BLOCKS];

  tldc_pkg::l1_meta_t             l1_meta_rd_q;
  logic [tldc_pkg::LINE_W-1:0]    l1_data_rd_q;
  tldc_pkg::l2_meta_t             l2_meta_rd_q;
  logic [tldc_pkg::LINE_W-1:0]    l2_data_rd_q;
  logic [tldc_pkg::LINE_W-1:0]    mem_rd_q;

  // cost registers
  logic [tldc_pkg::COST_W-1:0] mem_rd_cost_q, mem_wr_cost_q, l1_rd_cost_q, l1_wr_cost_q;
  logic [tldc_pkg::COST_W-1:0] l2_rd_cost_q, l2_wr_cost_q;

  // working registers
  tldc_pkg::item_t                op_q;
  logic [tldc_pkg::CLR_W-1:0]     clr_q;
  logic [tldc_pkg::BLK_W-1:0]     l2_blk_q;
  logic                           l2_wr_q, phase_q, keep2_q;
  logic                           hit1_q, hit2_q, err_q;
  tldc_pkg::l1_meta_t             vic1_q;
  tldc_pkg::l2_meta_t             vic2_q;
  logic [tldc_pkg::LINE_W-1:0]    vic1_line_q, vic2_line_q, l2line_q, line_q;
  logic [31:0]                    rdata_q;
  logic [tldc_pkg::TIME_W-1:0]    time_q;

  // derived fields
  logic [tldc_pkg::L1_IDX_W-1:0]  l1_idx;
  logic [tldc_pkg::L1_TAG_W-1:0]  l1_tag;
  logic [tldc_pkg::L2_IDX_W-1:0]  l2_idx;
  logic [tldc_pkg::L2_TAG_W-1:0]  l2_tag;
  logic                           l1_match, l2_match;
  logic [tldc_pkg::COST_W-1:0]    add_amt;
  logic [tldc_pkg::LINE_W-1:0]    merged_line;

  // memory write controls
  logic                           l1_we, l1_data_we, l2_we, mem_we;
  logic [tldc_pkg::L1_IDX_W-1:0]  l1_waddr;
  logic [tldc_pkg::L2_IDX_W-1:0]  l2_waddr;
  tldc_pkg::l1_meta_t             l1_meta_wd;
  tldc_pkg::l2_meta_t             l2_meta_wd;
  logic [tldc_pkg::LINE_W-1:0]    l2_data_wd;
  logic [tldc_pkg::BLK_W-1:0]     mem_waddr;

  assign l1_idx   = op_q.blk[tldc_pkg::L1_IDX_W-1:0];
  assign l1_tag   = op_q.blk[tldc_pkg::BLK_W-1:tldc_pkg::L1_IDX_W];
  assign l2_idx   = l2_blk_q[tldc_pkg::L2_IDX_W-1:0];
  assign l2_tag   = l2_blk_q[tldc_pkg::BLK_W-1:tldc_pkg::L2_IDX_W];
  assign l1_match = l1_meta_rd_q.valid && (l1_meta_rd_q.tag == l1_tag);
  assign l2_match = l2_meta_rd_q.valid && (l2_meta_rd_q.tag == l2_tag);
  assign pop_o    = (state_q == ST_IDLE) && q_i.valid;

  always_comb begin
    merged_line = line_q;
    merged_line[op_q.widx * tldc_pkg::WORD_W +: tldc_pkg::WORD_W] = op_q.wdata;
  end

  // per-state cost added to the counter
  always_comb begin
    add_amt = '0;
    unique case (state_q)
      ST_MEMCHK:  add_amt = mem_rd_cost_q;
      ST_MEMWB:   add_amt = mem_wr_cost_q;
      ST_L2APPLY: add_amt = l2_wr_q ? l2_wr_cost_q : l2_rd_cost_q;
      ST_WORD:    add_amt = op_q.wr ? l1_wr_cost_q : l1_rd_cost_q;
      default:    add_amt = '0;
    endcase
  end

  always_comb begin
    l1_we            = 1'b0;
    l1_data_we       = 1'b0;
    l2_we            = 1'b0;
    mem_we           = 1'b0;
    l1_waddr         = l1_idx;
    l2_waddr         = l2_idx;
    l1_meta_wd       = '0;
    l2_meta_wd       = '0;
    l2_data_wd       = l2_wr_q ? vic1_line_q : l2line_q;
    mem_waddr        = {vic2_q.tag, l2_idx};
    unique case (state_q)
      ST_CLEAR: begin
        l1_we    = 1'b1;
        l2_we    = 1'b1;
        l1_waddr = clr_q[tldc_pkg::L1_IDX_W-1:0];
        l2_waddr = clr_q[tldc_pkg::L2_IDX_W-1:0];
      end
      ST_MEMWB: begin
        mem_we = 1'b1;
      end
      ST_L2APPLY: begin
        l2_we            = 1'b1;
        l2_meta_wd.valid = 1'b1;
        l2_meta_wd.dirty = l2_wr_q | keep2_q;
        l2_meta_wd.tag   = l2_tag;
      end
      ST_WORD: begin
        l1_we            = 1'b1;
        l1_data_we       = 1'b1;
        l1_meta_wd.valid = 1'b1;
        l1_meta_wd.dirty = op_q.wr | (hit1_q & vic1_q.dirty);
        l1_meta_wd.tag   = l1_tag;
      end
      default: begin
      end
    endcase
  end

  // L1 arrays
  always_ff @(posedge clk_i) begin
    if (l1_we) begin
      l1_meta_mem[l1_waddr] <= l1_meta_wd;
    end
    if (l1_data_we) begin
      l1_data_mem[l1_waddr] <= op_q.wr ? merged_line : line_q;
    end
    l1_meta_rd_q <= l1_meta_mem[l1_idx];
    l1_data_rd_q <= l1_data_mem[l1_idx];
  end

  // L2 arrays; only the metadata is rewritten in the clear pass, so data stays undefined there
  always_ff @(posedge clk_i) begin
    if (l2_we) begin
      l2_meta_mem[l2_waddr] <= l2_meta_wd;
    end
    if (l2_we && (state_q == ST_L2APPLY)) begin
      l2_data_mem[l2_waddr] <= l2_data_wd;
    end
    l2_meta_rd_q <= l2_meta_mem[l2_idx];
    l2_data_rd_q <= l2_data_mem[l2_idx];
  end

  // main memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      main_mem[mem_waddr] <= vic2_line_q;
    end
    mem_rd_q <= main_mem[l2_blk_q];
  end

  // cost registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_rd_cost_q <= tldc_pkg::COST_W'(100);
      mem_wr_cost_q <= tldc_pkg::COST_W'(50);
      l1_rd_cost_q  <= tldc_pkg::COST_W'(1);
      l1_wr_cost_q  <= tldc_pkg::COST_W'(1);
      l2_rd_cost_q  <= tldc_pkg::COST_W'(10);
      l2_wr_cost_q  <= tldc_pkg::COST_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tldc_pkg::REG_MEM_RD: mem_rd_cost_q <= cfg_wdata_i;
        tldc_pkg::REG_MEM_WR: mem_wr_cost_q <= cfg_wdata_i;
        tldc_pkg::REG_L1_RD:  l1_rd_cost_q  <= cfg_wdata_i;
        tldc_pkg::REG_L1_WR:  l1_wr_cost_q  <= cfg_wdata_i;
        tldc_pkg::REG_L2_RD:  l2_rd_cost_q  <= cfg_wdata_i;
        tldc_pkg::REG_L2_WR:  l2_wr_cost_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      time_q         <= '0;
      out_valid_o    <= 1'b0;
      op_q           <= '0;
      l2_blk_q       <= '0;
      l2_wr_q        <= 1'b0;
      phase_q        <= 1'b0;
      keep2_q        <= 1'b0;
      hit1_q         <= 1'b0;
      hit2_q         <= 1'b0;
      err_q          <= 1'b0;
      vic1_q         <= '0;
      vic2_q         <= '0;
      rdata_q        <= '0;
      read_word_o    <= '0;
      l1_hit_o       <= 1'b0;
      l2_hit_o       <= 1'b0;
      elapsed_time_o <= '0;
      range_error_o  <= 1'b0;
    end else begin
      time_q <= time_q + tldc_pkg::TIME_W'(add_amt);
      // in ST_DONE the result register is reloaded below instead
      if (out_valid_o && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == tldc_pkg::CLR_W'(tldc_pkg::CLR_LINES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_i.valid) begin
            op_q    <= q_i.item;
            hit1_q  <= 1'b0;
            hit2_q  <= 1'b0;
            rdata_q <= '0;
            err_q   <= q_i.item.range_err;
            state_q <= q_i.item.range_err ? ST_DONE : ST_L1RD;
          end
        end
        ST_L1RD: state_q <= ST_L1CHK;
        ST_L1CHK: begin
          hit1_q      <= l1_match;
          vic1_q      <= l1_meta_rd_q;
          vic1_line_q <= l1_data_rd_q;
          line_q      <= l1_data_rd_q;
          if (l1_match) begin
            state_q <= ST_WORD;
          end else begin
            l2_blk_q <= op_q.blk;
            l2_wr_q  <= 1'b0;
            phase_q  <= 1'b0;
            state_q  <= ST_L2RD;
          end
        end
        ST_L2RD: state_q <= ST_L2CHK;
        ST_L2CHK: begin
          if (!phase_q) begin
            hit2_q <= l2_match;
          end
          keep2_q     <= l2_match & l2_meta_rd_q.dirty;
          l2line_q    <= l2_data_rd_q;
          vic2_q      <= l2_meta_rd_q;
          vic2_line_q <= l2_data_rd_q;
          state_q     <= l2_match ? ST_L2APPLY : ST_MEMRD;
        end
        ST_MEMRD: state_q <= ST_MEMCHK;
        ST_MEMCHK: begin
          l2line_q <= mem_rd_q;
          state_q  <= (vic2_q.valid && vic2_q.dirty) ? ST_MEMWB : ST_L2APPLY;
        end
        ST_MEMWB: state_q <= ST_L2APPLY;
        ST_L2APPLY: begin
          if (!l2_wr_q) begin
            line_q <= l2line_q;
          end
          if (!phase_q && vic1_q.valid && vic1_q.dirty) begin
            phase_q  <= 1'b1;
            l2_wr_q  <= 1'b1;
            l2_blk_q <= {vic1_q.tag, l1_idx};
            state_q  <= ST_L2RD;
          end else begin
            state_q <= ST_WORD;
          end
        end
        ST_WORD: begin
          rdata_q <= op_q.wr ? '0 : line_q[op_q.widx * tldc_pkg::WORD_W +: tldc_pkg::WORD_W];
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o    <= 1'b1;
            read_word_o    <= rdata_q;
            l1_hit_o       <= hit1_q;
            l2_hit_o       <= hit2_q;
            elapsed_time_o <= time_q;
            range_error_o  <= err_q;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/two_level_direct_mapped_writeback_cache_unit.sv
`timescale 1ns / 1ps
// L1 hit: L1 read, L1 check, word and done states from accept to result word;
// out of range: straight to done. An L1 miss adds L2 read, check and apply states
// per L2 access, plus memory read and check for a fetch and a write-back state per
// memory write-back. One word in the engine at a time; input queue takes 2 more.
// Reset: asynchronous; then a pass clears L1/L2 tags and valid bits,
// during which no word is started (config writes still taken).
module two_level_direct_mapped_writeback_cache_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [31:0]                    address_i,
  input  logic [31:0]                    write_word_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    read_word_o,
  output logic                           l1_hit_o,
  output logic                           l2_hit_o,
  output logic [31:0]                    elapsed_time_o,
  output logic                           range_error_o,
  // cost registers
  input  logic                           cfg_we_i,
  input  logic [tldc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tldc_pkg::COST_W-1:0]    cfg_wdata_i
);

  // decoded words flow front -> back through a two-entry queue
  tldc_pkg::q_out_t q;
  logic             pop;

  tldc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .address_i    (address_i),
    .write_word_i (write_word_i),
    .q_o          (q),
    .pop_i        (pop)
  );

  // engine: fetch-first refill, then dirty victim write-back a level down
  tldc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .pop_o          (pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_word_o    (read_word_o),
    .l1_hit_o       (l1_hit_o),
    .l2_hit_o       (l2_hit_o),
    .elapsed_time_o (elapsed_time_o),
    .range_error_o  (range_error_o)
  );

endmodule

>>> dv/cache_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the two-level cache: tracks both channels and predicts each result word.
module cache_result_checker
  import tldc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 action_i,
  input  logic [31:0]          address_i,
  input  logic [31:0]          write_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [31:0]          read_word_i,
  input  logic                 l1_hit_i,
  input  logic                 l2_hit_i,
  input  logic [31:0]          elapsed_time_i,
  input  logic                 range_error_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COST_W-1:0]    cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic [31:0] read_word;
    logic        read_known;
    logic        l1_hit;
    logic        l2_hit;
    logic [31:0] elapsed_time;
    logic        range_error;
  } cache_result_t;

  // line state; known masks mark words with defined contents (one bit per word)
  logic                l1_vld [L1_LINE_COUNT];
  logic                l1_drt [L1_LINE_COUNT];
  logic [L1_TAG_W-1:0] l1_tg  [L1_LINE_COUNT];
  logic [LINE_W-1:0]   l1_dat [L1_LINE_COUNT];
  logic [15:0]         l1_knw [L1_LINE_COUNT];
  logic                l2_vld [L2_LINE_COUNT];
  logic                l2_drt [L2_LINE_COUNT];
  logic [L2_TAG_W-1:0] l2_tg  [L2_LINE_COUNT];
  logic [LINE_W-1:0]   l2_dat [L2_LINE_COUNT];
  logic [15:0]         l2_knw [L2_LINE_COUNT];
  logic [LINE_W-1:0]   mem_dat [int];
  logic [15:0]         mem_knw [int];

  logic [31:0] clock_units;
  logic [15:0] cost_mem_rd, cost_mem_wr, cost_l1_rd, cost_l1_wr, cost_l2_rd, cost_l2_wr;
  cache_result_t awaited[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = awaited.size();

  function automatic void mem_xfer(input int blk, inout logic [LINE_W-1:0] d,
                                   inout logic [15:0] k, input bit wr);
    if (wr) begin
      mem_dat[blk] = d;
      mem_knw[blk] = k;
      clock_units += cost_mem_wr;
    end else begin
      d = mem_dat.exists(blk) ? mem_dat[blk] : '0;
      k = mem_knw.exists(blk) ? mem_knw[blk] : '0;
      clock_units += cost_mem_rd;
    end
  endfunction

  function automatic bit l2_xfer(input logic [BLK_W-1:0] blk, inout logic [LINE_W-1:0] d,
                                 inout logic [15:0] k, input bit wr);
    logic [L2_IDX_W-1:0] ix;
    logic [L2_TAG_W-1:0] tg;
    logic [LINE_W-1:0]   fd;
    logic [15:0]         fk;
    bit                  hit;
    ix  = blk[L2_IDX_W-1:0];
    tg  = blk[BLK_W-1:L2_IDX_W];
    hit = l2_vld[ix] && l2_tg[ix] == tg;
    if (!hit) begin
      mem_xfer(int'(blk), fd, fk, 1'b0);
      if (l2_vld[ix] && l2_drt[ix]) mem_xfer(int'({l2_tg[ix], ix}), l2_dat[ix], l2_knw[ix], 1'b1);
      l2_dat[ix] = fd;
      l2_knw[ix] = fk;
      l2_vld[ix] = 1'b1;
      l2_tg[ix]  = tg;
      l2_drt[ix] = 1'b0;
    end
    if (wr) begin
      l2_dat[ix] = d;
      l2_knw[ix] = k;
      l2_drt[ix] = 1'b1;
      clock_units += cost_l2_wr;
    end else begin
      d = l2_dat[ix];
      k = l2_knw[ix];
      clock_units += cost_l2_rd;
    end
    return hit;
  endfunction

  function automatic cache_result_t predict_access(input logic wr, input logic [31:0] addr,
                                                   input logic [31:0] wdata);
    cache_result_t       r;
    logic [BLK_W-1:0]    blk;
    logic [L1_IDX_W-1:0] ix;
    logic [L1_TAG_W-1:0] tg;
    logic [3:0]          w;
    logic [LINE_W-1:0]   fd;
    logic [15:0]         fk;
    r = '{default: '0};
    if (addr >= MEMORY_BYTES) begin
      r.range_error  = 1'b1;
      r.read_known   = 1'b1;
      r.elapsed_time = clock_units;
      return r;
    end
    blk = addr[ADDR_W-1:OFF_W];
    ix  = blk[L1_IDX_W-1:0];
    tg  = blk[BLK_W-1:L1_IDX_W];
    w   = addr[OFF_W-1:2];
    r.l1_hit = l1_vld[ix] && l1_tg[ix] == tg;
    if (!r.l1_hit) begin
      r.l2_hit = l2_xfer(blk, fd, fk, 1'b0);
      if (l1_vld[ix] && l1_drt[ix])
        void'(l2_xfer({l1_tg[ix], ix}, l1_dat[ix], l1_knw[ix], 1'b1));
      l1_dat[ix] = fd;
      l1_knw[ix] = fk;
      l1_vld[ix] = 1'b1;
      l1_tg[ix]  = tg;
      l1_drt[ix] = 1'b0;
    end
    if (wr) begin
      l1_dat[ix][w*32 +: 32] = wdata;
      l1_knw[ix][w] = 1'b1;
      l1_drt[ix] = 1'b1;
      clock_units += cost_l1_wr;
      r.read_known = 1'b1;
    end else begin
      r.read_word  = l1_dat[ix][w*32 +: 32];
      r.read_known = l1_knw[ix][w];
      clock_units += cost_l1_rd;
    end
    r.elapsed_time = clock_units;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < L1_LINE_COUNT; i++) begin
        l1_vld[i] = 0; l1_drt[i] = 0; l1_tg[i] = '0; l1_knw[i] = '0; l1_dat[i] = '0;
      end
      for (int i = 0; i < L2_LINE_COUNT; i++) begin
        l2_vld[i] = 0; l2_drt[i] = 0; l2_tg[i] = '0; l2_knw[i] = '0; l2_dat[i] = '0;
      end
      mem_dat.delete();
      mem_knw.delete();
      awaited.delete();
      clock_units = '0;
      fails       = 0;
      cost_mem_rd = 16'd100; cost_mem_wr = 16'd50;
      cost_l1_rd  = 16'd1;   cost_l1_wr  = 16'd1;
      cost_l2_rd  = 16'd10;  cost_l2_wr  = 16'd5;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MEM_RD: cost_mem_rd = cfg_wdata_i;
          REG_MEM_WR: cost_mem_wr = cfg_wdata_i;
          REG_L1_RD:  cost_l1_rd  = cfg_wdata_i;
          REG_L1_WR:  cost_l1_wr  = cfg_wdata_i;
          REG_L2_RD:  cost_l2_rd  = cfg_wdata_i;
          REG_L2_WR:  cost_l2_wr  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          e = awaited.pop_front();
          if (e.read_known && read_word_i !== e.read_word) begin
            $error("read_word exp %h got %h", e.read_word, read_word_i); fails++;
          end
          if (l1_hit_i !== e.l1_hit) begin
            $error("l1_hit exp %0d got %0d", e.l1_hit, l1_hit_i); fails++;
          end
          if (l2_hit_i !== e.l2_hit) begin
            $error("l2_hit exp %0d got %0d", e.l2_hit, l2_hit_i); fails++;
          end
          if (elapsed_time_i !== e.elapsed_time) begin
            $error("elapsed_time exp %h got %h", e.elapsed_time, elapsed_time_i); fails++;
          end
          if (range_error_i !== e.range_error) begin
            $error("range_error exp %0d got %0d", e.range_error, range_error_i); fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited.push_back(predict_access(action_i, address_i, write_word_i));
    end
  end

endmodule

>>> dv/two_level_direct_mapped_writeback_cache_unit_test.sv
`timescale 1ns / 1ps
// Top of the two-level cache testbench: stimulus, cost register phases and verdict.
module two_level_direct_mapped_writeback_cache_unit_test;
  import tldc_pkg::*;

  // index past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam bit ACT_READ  = 1'b0;
  localparam bit ACT_WRITE = 1'b1;

  logic                 clk_i, rst_ni;
  logic                 in_valid, in_stall, action;
  logic [31:0]          address, write_word;
  logic                 out_valid, out_stall;
  logic [31:0]          read_word, elapsed_time;
  logic                 l1_hit, l2_hit, range_error;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COST_W-1:0]    cfg_wdata;
  int                   fail_count, pending;

  int          burst_left;
  logic [31:0] stored_addrs[$];

  two_level_direct_mapped_writeback_cache_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .action_i(action),
    .address_i(address), .write_word_i(write_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .read_word_o(read_word),
    .l1_hit_o(l1_hit), .l2_hit_o(l2_hit), .elapsed_time_o(elapsed_time),
    .range_error_o(range_error),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  cache_result_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .action_i(action),
    .address_i(address), .write_word_i(write_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .read_word_i(read_word),
    .l1_hit_i(l1_hit), .l2_hit_i(l2_hit), .elapsed_time_i(elapsed_time),
    .range_error_i(range_error),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver stall: alternating stretches of no stall, light and heavy stall.
  initial begin
    int mode, span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // hard stop
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Present one word and hold it until taken; drop valid only at a burst end.
  task automatic push_word(input bit act, input logic [31:0] addr, input logic [31:0] data);
    in_valid   <= 1'b1;
    action     <= act;
    address    <= addr;
    write_word <= data;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (act == ACT_WRITE && addr < MEMORY_BYTES) stored_addrs.push_back(addr);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(0, 12);
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Engine may still be busy after its last word; wait until no result is pending, then idle.
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // write enable stays high across back-to-back writes; the caller drops it
  task automatic set_cost(input logic [CFG_IDX_W-1:0] idx, input logic [COST_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic set_all_costs(input int how);
    logic [COST_W-1:0] v;
    for (int i = 0; i <= int'(REG_L2_WR); i++) begin
      case (how)
        0: v = '0;
        1: v = '1;
        default: v = COST_W'($urandom_range(0, 65535));
      endcase
      set_cost(cfg_reg_e'(i), v);
    end
    set_cost(REG_UNUSED, 16'h1234);
    cfg_we <= 1'b0;
  endtask

  // Most addresses land on a few L1/L2 sets so hits, evictions and dirty write-backs occur.
  function automatic logic [31:0] pick_addr();
    logic [13:0] blk;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return $urandom();
    if (sel < 25) return $urandom_range(0, MEMORY_BYTES - 1);
    blk = {6'($urandom_range(0, 63)), 8'(0)} | 14'($urandom_range(0, 3));
    return {12'd0, blk, 6'($urandom_range(0, 63))};
  endfunction

  task automatic random_words(input int count);
    logic [31:0] a;
    repeat (count) begin
      if ($urandom_range(0, 99) < 55 && stored_addrs.size() != 0) begin
        a = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
        push_word(ACT_READ, a, $urandom());
      end else begin
        push_word(ACT_WRITE, pick_addr(), $urandom());
      end
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    action     = 1'b0;
    address    = '0;
    write_word = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    burst_left = 0;
    rst_ni     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, hits, conflict evictions at both levels, out of range
    push_word(ACT_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    push_word(ACT_READ,  32'h0000_0003, 32'h0);
    push_word(ACT_WRITE, 32'h0000_003C, 32'h0000_0000);
    push_word(ACT_WRITE, MEMORY_BYTES - 1, 32'hA5C3_5A3C);
    push_word(ACT_READ,  MEMORY_BYTES - 4, 32'h0);
    push_word(ACT_READ,  MEMORY_BYTES, 32'h0);
    push_word(ACT_WRITE, 32'hFFFF_FFFF, 32'h1234_5678);
    push_word(ACT_READ,  32'h8000_0000, 32'h0);
    // same L1 set, different tags: dirty L1 victim into L2
    push_word(ACT_WRITE, 32'h0000_4000, 32'h1111_1111);
    push_word(ACT_READ,  32'h0000_0000, 32'h0);
    // same L2 set as well: dirty L2 victim into memory
    push_word(ACT_WRITE, 32'h0000_8000, 32'h2222_2222);
    push_word(ACT_WRITE, 32'h0001_0000, 32'h3333_3333);
    push_word(ACT_WRITE, 32'h0001_8000, 32'h4444_4444);
    push_word(ACT_READ,  32'h0000_8000, 32'h0);
    push_word(ACT_READ,  32'h0000_4000, 32'h0);
    push_word(ACT_READ,  32'h0000_0000, 32'h0);
    push_word(ACT_READ,  32'h0001_0000, 32'h0);
    push_word(ACT_READ,  32'h0001_8000, 32'h0);
    random_words(80);

    // cost phases: all zero, all maximum, random
    drain_all();
    set_all_costs(0);
    random_words(90);
    drain_all();
    set_all_costs(1);
    random_words(120);
    drain_all();
    set_all_costs(2);
    random_words(90);
    drain_all();
    set_all_costs(2);
    random_words(70);

    drain_all();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
